// File: rtl/core/pdic_pkg.sv
// ----------------------------------------------------------------------------
// Interval coalescer package
// Field widths, the slot word kept in the table memory and the shared
// signed-difference threshold compare.
// ----------------------------------------------------------------------------
package pdic_pkg;

  localparam int unsigned TIME_W  = 63;
  localparam int unsigned INDEX_W = 32;
  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned APB_DW  = 64;
  localparam int unsigned APB_AW  = 4;

  // Register byte addresses; bit 3 of the address selects the register.
  localparam logic [APB_AW-1:0] REG_MIN_LENGTH = 4'h0;
  localparam logic [APB_AW-1:0] REG_MIN_GAP    = 4'h8;

  localparam logic CMD_INTERVAL = 1'b0;
  localparam logic CMD_FLUSH    = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  end_time;
    logic [INDEX_W-1:0] trace_index;
    logic               merged;
  } slot_t;

  // True when a - b, taken as a signed 64-bit value, is negative or lies
  // below the unsigned threshold.
  function automatic logic diff_below(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b,
                                      input logic [TIME_W-1:0] thr);
    logic [TIME_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    return d[TIME_W] | (d[TIME_W-1:0] < thr);
  endfunction

endpackage

// File: rtl/core/per_depth_interval_coalescer.sv
// ----------------------------------------------------------------------------
// Per-depth interval coalescer
// Keeps one pending interval per nesting depth in a synchronous table memory
// and merges short, close intervals at the same depth; a flush drains the table.
// ----------------------------------------------------------------------------
// Interval word: busy while the slot is read and then merged and written back,
//   so no new word is taken before it is through; a displaced result and a
//   depth outside the table are returned through the result register.
// Flush: walks the table one slot per cycle and stays busy past the last slot;
//   each valid slot passes the read register and tag before the result.
// Reset clears the valid bits and most registers; the receiver cannot stall.
module per_depth_interval_coalescer #(
  parameter int unsigned DEPTH_SLOTS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Command channel
  input  logic                            start,
  output logic                            busy,
  input  logic                            cmd_i,
  input  logic [pdic_pkg::TIME_W-1:0]     start_time_i,
  input  logic [pdic_pkg::TIME_W-1:0]     end_time_i,
  input  logic [pdic_pkg::INDEX_W-1:0]    trace_index_i,
  input  logic [pdic_pkg::DEPTH_W-1:0]    nest_depth_i,
  // Result channel
  output logic                            result_valid_o,
  output logic [pdic_pkg::TIME_W-1:0]     out_start_o,
  output logic [pdic_pkg::TIME_W-1:0]     out_end_o,
  output logic [pdic_pkg::INDEX_W-1:0]    out_index_o,
  output logic [pdic_pkg::DEPTH_W-1:0]    out_depth_o,
  output logic                            merged_o,
  output logic                            last_o,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pdic_pkg::APB_AW-1:0]     paddr,
  input  logic [pdic_pkg::APB_DW-1:0]     pwdata,
  output logic [pdic_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int unsigned AW = (DEPTH_SLOTS > 1) ? $clog2(DEPTH_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_FLUSH,
    ST_FL_END
  } state_e;

  state_e                        state_q;
  logic [DEPTH_SLOTS-1:0]        valid_q;
  logic [pdic_pkg::TIME_W-1:0]   min_length_q;
  logic [pdic_pkg::TIME_W-1:0]   min_gap_q;

  // Request held across the read cycle.
  logic [pdic_pkg::TIME_W-1:0]   req_start_q;
  logic [pdic_pkg::TIME_W-1:0]   req_end_q;
  logic [pdic_pkg::INDEX_W-1:0]  req_index_q;
  logic [AW-1:0]                 req_addr_q;
  logic                          req_short_q;

  // Flush walk and its one-stage read tag.
  logic [AW-1:0]                 cnt_q;
  logic                          fl_hit_q;
  logic                          fl_last_q;
  logic [AW-1:0]                 fl_addr_q;

  // Table memory.
  pdic_pkg::slot_t               mem [DEPTH_SLOTS];
  pdic_pkg::slot_t               rdata_q;
  pdic_pkg::slot_t               mem_wdata;
  logic                          mem_we;
  logic [AW-1:0]                 mem_raddr;

  // Result registers.
  logic                          res_valid_q;
  pdic_pkg::slot_t               res_q;
  logic [pdic_pkg::DEPTH_W-1:0]  res_depth_q;
  logic                          res_last_q;

  logic                          accept;
  logic                          in_table;
  logic                          cfg_we;
  logic                          old_valid;
  logic                          do_merge;
  logic [DEPTH_SLOTS-1:0]        above;
  logic                          none_above;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start & ~busy;
  assign in_table = ({1'b0, nest_depth_i} < (pdic_pkg::DEPTH_W + 1)'(DEPTH_SLOTS));

  assign cfg_we = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign prdata = paddr[3] ? {1'b0, min_gap_q} : {1'b0, min_length_q};

  assign mem_raddr = (state_q == ST_FLUSH) ? cnt_q : nest_depth_i[AW-1:0];

  // Merge decision on the slot read back from the table.
  assign old_valid = valid_q[req_addr_q];
  assign do_merge  = old_valid & req_short_q
                   & pdic_pkg::diff_below(rdata_q.end_time, rdata_q.start_time, min_length_q)
                   & pdic_pkg::diff_below(req_start_q, rdata_q.end_time, min_gap_q);

  always_comb begin
    mem_we    = (state_q == ST_RD);
    mem_wdata = '{start_time:  do_merge ? rdata_q.start_time : req_start_q,
                  end_time:    req_end_q,
                  trace_index: req_index_q,
                  merged:      do_merge};
  end

  // Slots above the current flush position that still hold an interval.
  always_comb begin
    for (int i = 0; i < DEPTH_SLOTS; i++) begin
      above[i] = ((AW + 1)'(i) > {1'b0, cnt_q});
    end
    none_above = ~|(valid_q & above);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[req_addr_q] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_start_q <= start_time_i;
      req_end_q   <= end_time_i;
      req_index_q <= trace_index_i;
      req_addr_q  <= nest_depth_i[AW-1:0];
      req_short_q <= pdic_pkg::diff_below(end_time_i, start_time_i, min_length_q);
    end
    fl_addr_q <= cnt_q;
    fl_last_q <= none_above;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_length_q <= '0;
      min_gap_q    <= '0;
    end else if (cfg_we) begin
      if (paddr[3] == pdic_pkg::REG_MIN_GAP[3]) begin
        min_gap_q <= pwdata[pdic_pkg::TIME_W-1:0];
      end else begin
        min_length_q <= pwdata[pdic_pkg::TIME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      cnt_q       <= '0;
      fl_hit_q    <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      res_depth_q <= '0;
      res_last_q  <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      fl_hit_q    <= 1'b0;
      // A tagged flush read is moved from the read register into the result.
      if (fl_hit_q) begin
        res_valid_q <= 1'b1;
        res_q       <= rdata_q;
        res_depth_q <= pdic_pkg::DEPTH_W'(fl_addr_q);
        res_last_q  <= fl_last_q;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (cmd_i == pdic_pkg::CMD_FLUSH) begin
              cnt_q   <= '0;
              state_q <= ST_FLUSH;
            end else if (in_table) begin
              state_q <= ST_RD;
            end else begin
              res_valid_q <= 1'b1;
              res_q       <= '{start_time:  start_time_i,
                               end_time:    end_time_i,
                               trace_index: trace_index_i,
                               merged:      1'b0};
              res_depth_q <= nest_depth_i;
              res_last_q  <= 1'b1;
            end
          end
        end
        ST_RD: begin
          if (old_valid && !do_merge) begin
            res_valid_q <= 1'b1;
            res_q       <= rdata_q;
            res_depth_q <= pdic_pkg::DEPTH_W'(req_addr_q);
            res_last_q  <= 1'b1;
          end
          valid_q[req_addr_q] <= 1'b1;
          state_q             <= ST_IDLE;
        end
        ST_FLUSH: begin
          fl_hit_q       <= valid_q[cnt_q];
          valid_q[cnt_q] <= 1'b0;
          if (cnt_q == LAST_SLOT) begin
            state_q <= ST_FL_END;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FL_END: begin
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign out_start_o    = res_q.start_time;
  assign out_end_o      = res_q.end_time;
  assign out_index_o    = res_q.trace_index;
  assign merged_o       = res_q.merged;
  assign out_depth_o    = res_depth_q;
  assign last_o         = res_last_q;

  // The whole table is empty once the flush walk has passed the last slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FL_END) |-> (valid_q == '0))
    else $error("table not empty after flush walk");

  // No flush read may still be in flight while the block takes new words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !fl_hit_q)
    else $error("flush read pending while idle");

  // An in-table interval word always goes through the table read cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i == pdic_pkg::CMD_INTERVAL) && in_table) |=> (state_q == ST_RD))
    else $error("interval word skipped the table read");

  // After the read-modify-write the addressed slot holds an interval.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (state_q == ST_IDLE) && ((valid_q & ~$past(valid_q)) != '0
      || $past(old_valid)))
    else $error("slot not marked pending after write-back");

  // A merge never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD && do_merge) |=> !result_valid_o)
    else $error("result emitted on merge");

endmodule
